[rtl/core/bdc_pkg.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer package
// Shared types, display operation codes, character codes and the glyph and
// digit tables used by the renderer core.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // Kinds of display operation.
  localparam logic [1:0] KIND_CELL  = 2'd0;
  localparam logic [1:0] KIND_BLANK = 2'd1;
  localparam logic [1:0] KIND_GLYPH = 2'd2;

  // Input command codes.
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RELOAD = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_M     = 8'd77;

  // Cell codes of each big digit: top-left, top-right, bottom-left, bottom-right.
  localparam logic [7:0] DIGIT_CELLS [10][4] = '{
    '{8'd5, 8'd255, 8'd7,  8'd6},
    '{8'd0, 8'd1,   8'd2,  8'd7},
    '{8'd0, 8'd3,   8'd4,  8'd2},
    '{8'd0, 8'd3,   8'd2,  8'd3},
    '{8'd1, 8'd1,   8'd0,  8'd5},
    '{8'd4, 8'd0,   8'd2,  8'd3},
    '{8'd5, 8'd0,   8'd4,  8'd3},
    '{8'd0, 8'd3,   8'd32, 8'd1},
    '{8'd4, 8'd3,   8'd4,  8'd3},
    '{8'd4, 8'd3,   8'd2,  8'd6}
  };

  // Pixel rows of the eight custom glyphs, top row in the upper bits.
  localparam logic [39:0] GLYPH_ROWS [8] = '{
    {5'h1F, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    {5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h1F},
    {5'h1F, 5'h1F, 5'h03, 5'h03, 5'h03, 5'h03, 5'h1F, 5'h1F},
    {5'h1F, 5'h1F, 5'h18, 5'h18, 5'h18, 5'h18, 5'h1F, 5'h1F},
    {5'h1F, 5'h1F, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18},
    {5'h03, 5'h03, 5'h03, 5'h03, 5'h03, 5'h03, 5'h1F, 5'h1F},
    {5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h1F, 5'h1F}
  };

  // One input item.
  typedef struct packed {
    logic       cmd;
    logic [4:0] hour;
    logic [5:0] minute;
  } in_item_t;

  // One display operation.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  col;
    logic        row;
    logic [7:0]  code;
    logic [2:0]  slot;
    logic [39:0] glyph;
    logic        last;
  } out_item_t;

  // One draw job handed from the front end to the sequencer.
  typedef struct packed {
    logic       full_draw;
    logic [3:0] hour12;
    logic [2:0] min_tens;
    logic [3:0] min_ones;
    logic       pm;
  } job_t;

endpackage

[rtl/core/bdc_front.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer front end
// Accepts input items, keeps the draw history and glyph state, drops repeated
// draws, reload notices and all items with no display, and turns the rest into jobs.
// ----------------------------------------------------------------------------
module bdc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              push_i,
  input  bdc_pkg::in_item_t in_item_i,
  input  logic              job_full_i,
  output logic              job_push_o,
  output bdc_pkg::job_t     job_o
);

  logic       display_present_q;
  logic [3:0] last_hour12_q, last_hour12_d;
  logic [5:0] last_minute_q, last_minute_d;
  logic       last_valid_q, last_valid_d;
  logic       glyphs_normal_q, glyphs_normal_d;

  logic       accept;
  logic [4:0] hour_wrap;
  logic [3:0] hour12;
  logic       pm;
  logic [9:0] tens_prod;
  logic [2:0] min_tens;
  logic [6:0] tens_times_ten;
  logic [5:0] min_ones_full;
  logic       repeat_draw;

  assign accept = push_i && !job_full_i;

  // Fold the hour into the 12-hour form; zero shows as twelve.
  always_comb begin
    if (in_item_i.hour >= 5'd24) begin
      hour_wrap = in_item_i.hour - 5'd24;
    end else if (in_item_i.hour >= 5'd12) begin
      hour_wrap = in_item_i.hour - 5'd12;
    end else begin
      hour_wrap = in_item_i.hour;
    end
    hour12 = (hour_wrap == 5'd0) ? 4'd12 : hour_wrap[3:0];
    pm     = (in_item_i.hour >= 5'd12);
  end

  // Split the minute into digits: tens by reciprocal multiply, exact up to 63.
  assign tens_prod      = 10'(in_item_i.minute) * 10'd13;
  assign min_tens       = tens_prod[9:7];
  assign tens_times_ten = 7'(min_tens) * 7'd10;
  assign min_ones_full  = in_item_i.minute - tens_times_ten[5:0];

  assign repeat_draw = last_valid_q && (last_hour12_q == hour12) &&
                       (last_minute_q == in_item_i.minute) && !glyphs_normal_q;

  // Job handed to the sequencer.
  assign job_push_o = accept && display_present_q && (in_item_i.cmd == bdc_pkg::CMD_DRAW) &&
                      !repeat_draw;
  always_comb begin
    job_o.full_draw = glyphs_normal_q;
    job_o.hour12    = hour12;
    job_o.min_tens  = min_tens;
    job_o.min_ones  = min_ones_full[3:0];
    job_o.pm        = pm;
  end

  // Next state of the draw history.
  always_comb begin
    last_hour12_d   = last_hour12_q;
    last_minute_d   = last_minute_q;
    last_valid_d    = last_valid_q;
    glyphs_normal_d = glyphs_normal_q;
    if (accept && display_present_q && (in_item_i.cmd == bdc_pkg::CMD_RELOAD)) begin
      glyphs_normal_d = 1'b1;
    end else if (job_push_o) begin
      last_hour12_d   = hour12;
      last_minute_d   = in_item_i.minute;
      last_valid_d    = 1'b1;
      glyphs_normal_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_present_q <= 1'b1;
      last_hour12_q     <= '0;
      last_minute_q     <= '0;
      last_valid_q      <= 1'b0;
      glyphs_normal_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        display_present_q <= cfg_wdata_i;
      end
      last_hour12_q   <= last_hour12_d;
      last_minute_q   <= last_minute_d;
      last_valid_q    <= last_valid_d;
      glyphs_normal_q <= glyphs_normal_d;
    end
  end

endmodule

[rtl/core/bdc_job_fifo.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer job queue
// Small first-in first-out queue of draw jobs between front end and sequencer.
// ----------------------------------------------------------------------------
module bdc_job_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bdc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bdc_pkg::job_t data_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bdc_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/bdc_back.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer sequencer
// Steps through one draw job, one display operation per cycle unless stalled,
// into an output register that holds each operation until it is taken.
// ----------------------------------------------------------------------------
module bdc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  input  bdc_pkg::job_t      job_i,
  output logic               job_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bdc_pkg::out_item_t out_item_o
);

  // Step numbers: two row blanks, eight glyph definitions, 32 cell writes.
  localparam logic [5:0] STEP_GLYPH = 6'd2;
  localparam logic [5:0] STEP_CELL  = 6'd10;
  localparam logic [5:0] STEP_LAST  = 6'd41;

  // Sources of a cell write.
  localparam logic [1:0] SRC_BIG  = 2'd0;
  localparam logic [1:0] SRC_PAIR = 2'd1;
  localparam logic [1:0] SRC_AMPM = 2'd2;

  logic               busy_q;
  logic [5:0]         step_q;
  bdc_pkg::job_t      job_q;
  logic               out_valid_q;
  bdc_pkg::out_item_t out_q;

  logic               advance, emit, final_step;
  logic               two_digit;
  logic [3:0]         hour_ones;
  logic [5:0]         glyph_off, cell_off;
  logic [4:0]         cell_idx;
  logic [1:0]         src;
  logic [3:0]         big_digit;
  logic [3:0]         big_col;
  logic [4:0]         big_start;
  logic [4:0]         big_diff;
  logic [1:0]         big_sub;
  logic [3:0]         pair_col;
  logic [7:0]         pair_code;
  bdc_pkg::out_item_t op;

  assign advance    = !out_valid_q || pop_i;
  assign emit       = busy_q && advance;
  assign final_step = (step_q == STEP_LAST);
  assign job_pop_o  = !job_empty_i && (!busy_q || (emit && final_step));

  assign two_digit = (job_q.hour12 >= 4'd10);
  assign hour_ones = two_digit ? job_q.hour12 - 4'd10 : job_q.hour12;
  assign glyph_off = step_q - STEP_GLYPH;
  assign cell_off  = step_q - STEP_CELL;
  assign cell_idx  = cell_off[4:0];

  // Map a cell index to its place in the layout.
  always_comb begin
    src       = SRC_PAIR;
    big_digit = '0;
    big_col   = '0;
    big_start = '0;
    pair_col  = '0;
    pair_code = bdc_pkg::CH_SPACE;
    if (two_digit) begin
      case (cell_idx) inside
        [5'd0:5'd3]: begin
          src = SRC_BIG; big_digit = 4'd1; big_col = 4'd0; big_start = 5'd0;
        end
        [5'd4:5'd5]:   pair_col = 4'd2;
        [5'd6:5'd9]: begin
          src = SRC_BIG; big_digit = hour_ones; big_col = 4'd3; big_start = 5'd6;
        end
        [5'd10:5'd11]: pair_col = 4'd5;
        [5'd12:5'd13]: begin
          pair_col = 4'd6; pair_code = bdc_pkg::CH_COLON;
        end
        [5'd14:5'd15]: pair_col = 4'd7;
        [5'd16:5'd19]: begin
          src = SRC_BIG; big_digit = 4'(job_q.min_tens); big_col = 4'd8; big_start = 5'd16;
        end
        [5'd20:5'd21]: pair_col = 4'd10;
        [5'd22:5'd25]: begin
          src = SRC_BIG; big_digit = job_q.min_ones; big_col = 4'd11; big_start = 5'd22;
        end
        [5'd26:5'd27]: pair_col = 4'd13;
        default:       src = SRC_AMPM;
      endcase
    end else begin
      case (cell_idx) inside
        [5'd0:5'd1]:   pair_col = 4'd0;
        [5'd2:5'd3]:   pair_col = 4'd1;
        [5'd4:5'd7]: begin
          src = SRC_BIG; big_digit = job_q.hour12; big_col = 4'd2; big_start = 5'd4;
        end
        [5'd8:5'd9]:   pair_col = 4'd4;
        [5'd10:5'd11]: begin
          pair_col = 4'd5; pair_code = bdc_pkg::CH_COLON;
        end
        [5'd12:5'd13]: pair_col = 4'd6;
        [5'd14:5'd17]: begin
          src = SRC_BIG; big_digit = 4'(job_q.min_tens); big_col = 4'd7; big_start = 5'd14;
        end
        [5'd18:5'd19]: pair_col = 4'd9;
        [5'd20:5'd23]: begin
          src = SRC_BIG; big_digit = job_q.min_ones; big_col = 4'd10; big_start = 5'd20;
        end
        [5'd24:5'd25]: pair_col = 4'd12;
        [5'd26:5'd27]: pair_col = 4'd13;
        default:       src = SRC_AMPM;
      endcase
    end
  end

  assign big_diff = cell_idx - big_start;
  assign big_sub  = big_diff[1:0];

  // Build the display operation for the current step.
  always_comb begin
    op       = '0;
    op.last  = final_step;
    if (step_q < STEP_GLYPH) begin
      op.kind = bdc_pkg::KIND_BLANK;
      op.row  = step_q[0];
      op.code = bdc_pkg::CH_SPACE;
    end else if (step_q < STEP_CELL) begin
      op.kind  = bdc_pkg::KIND_GLYPH;
      op.slot  = glyph_off[2:0];
      op.glyph = bdc_pkg::GLYPH_ROWS[glyph_off[2:0]];
    end else begin
      op.kind = bdc_pkg::KIND_CELL;
      case (src)
        SRC_BIG: begin
          op.col  = big_col + 4'(big_sub[0]);
          op.row  = big_sub[1];
          op.code = bdc_pkg::DIGIT_CELLS[big_digit][big_sub];
        end
        SRC_PAIR: begin
          op.col  = pair_col;
          op.row  = cell_idx[0];
          op.code = pair_code;
        end
        default: begin
          op.col = {3'b111, cell_idx[0]};
          op.row = cell_idx[1];
          if (job_q.pm) begin
            op.code = cell_idx[1] ? (cell_idx[0] ? bdc_pkg::CH_M : bdc_pkg::CH_P)
                                  : bdc_pkg::CH_SPACE;
          end else begin
            op.code = cell_idx[1] ? bdc_pkg::CH_SPACE
                                  : (cell_idx[0] ? bdc_pkg::CH_M : bdc_pkg::CH_A);
          end
        end
      endcase
    end
  end

  // Sequencer control: take the next job as soon as the current one ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        busy_q <= 1'b1;
        step_q <= job_i.full_draw ? '0 : STEP_CELL;
      end else if (emit) begin
        if (final_step) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Job and output payload registers.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= op;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

[rtl/core/big_digit_clock_renderer_core.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer core
// Draws a 12-hour clock in 2x2 big digits on a 16x2 character display as a
// stream of display operations.
// ----------------------------------------------------------------------------
// The front end takes one input item per cycle while the job queue has room;
// reload notices, repeated draws and any item while no display is present
// produce no operations; only a reload with a display present changes state.
// Each draw is queued as a job, and the sequencer emits its operations one
// per cycle into an output register while it is free or being taken: two
// row blanks, eight glyph definitions and 32 cell writes for a draw that
// first loads the big glyphs, the 32 cell writes for a plain redraw. The
// next waiting job is popped as the last operation of the one before is
// emitted. The sequencer's single operation per cycle sets the sustained rate;
// the output side may stall it at any time, and the JOB_DEPTH-entry queue lets input go on.
module big_digit_clock_renderer_core #(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               push_i,
  output logic               full_o,
  input  bdc_pkg::in_item_t  in_item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output bdc_pkg::out_item_t out_item_o
);

  logic          job_push, job_full, job_pop, job_empty;
  bdc_pkg::job_t job_in, job_out;

  assign full_o = job_full;

  // Front end: filter and classify items.
  bdc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .in_item_i   (in_item_i),
    .job_full_i  (job_full),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // Job queue between the two sides.
  bdc_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Sequencer: one display operation per cycle while the output is not stalled.
  bdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/core/bdc_checker.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer checker
// Assertions on the result stream seen at the core's ports.
// ----------------------------------------------------------------------------
module bdc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pop_i,
  input logic               empty_o,
  input bdc_pkg::out_item_t out_item_o
);

  // A waiting result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_item_o)))
    else $error("result changed while waiting for transfer");

  // Blanking row 0 is followed by blanking row 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && out_item_o.kind == bdc_pkg::KIND_BLANK && !out_item_o.row)
    ##1 !empty_o |-> (out_item_o.kind == bdc_pkg::KIND_BLANK && out_item_o.row))
    else $error("row 1 blank does not follow row 0 blank");

  // Glyph definitions come in ascending slot order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && out_item_o.kind == bdc_pkg::KIND_GLYPH && out_item_o.slot != 3'd7)
    ##1 !empty_o |-> (out_item_o.kind == bdc_pkg::KIND_GLYPH &&
                      out_item_o.slot == $past(out_item_o.slot) + 3'd1))
    else $error("glyph slots out of order");

  // The cell at column 14 of row 1 is followed by the final cell at column 15.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && out_item_o.kind == bdc_pkg::KIND_CELL &&
     out_item_o.col == 4'd14 && out_item_o.row)
    ##1 !empty_o |-> (out_item_o.col == 4'd15 && out_item_o.row && out_item_o.last))
    else $error("draw does not end on column 15 of row 1");

endmodule

bind big_digit_clock_renderer_core bdc_checker u_bdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop_i      (pop_i),
  .empty_o    (empty_o),
  .out_item_o (out_item_o)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Big-digit clock renderer core testbench
// Drives time draws and glyph reload notices into the renderer core. A
// predictor works out every display operation, and each popped operation is
// checked field by field against the oldest one that is still pending.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;

  // Block ports; the inputs are driven to known values from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b1;
  logic               push_i      = 1'b0;
  logic               full_o;
  bdc_pkg::in_item_t  in_item_i   = '0;
  logic               empty_o;
  logic               pop_i       = 1'b0;
  bdc_pkg::out_item_t out_item_o;

  // Predictor state and the display operations still to come.
  logic               present_q       = 1'b1;
  logic [3:0]         last_h12_q      = '0;
  logic [5:0]         last_min_q      = '0;
  logic               drawn_q         = 1'b0;
  logic               glyphs_loaded_q = 1'b1;
  bdc_pkg::out_item_t pending_ops[$];

  // Traffic shaping and bookkeeping.
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       hold_left     = 0;
  int unsigned       cycle_count   = 0;
  int unsigned       n_errors      = 0;
  int unsigned       n_items       = 0;
  int unsigned       n_ops_checked = 0;
  int unsigned       n_full_draws  = 0;
  int unsigned       n_redraws     = 0;
  int unsigned       n_skipped     = 0;
  int unsigned       n_reloads     = 0;
  bdc_pkg::in_item_t last_sent_q   = '0;

  big_digit_clock_renderer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_item_i   (in_item_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit: a stuck block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Cell codes of one big digit, top-left first.
  function automatic logic [7:0] digit_code(int unsigned d, int unsigned pos);
    logic [31:0] cells;
    case (d)
      0: cells = {8'd5, 8'd255, 8'd7, 8'd6};
      1: cells = {8'd0, 8'd1, 8'd2, 8'd7};
      2: cells = {8'd0, 8'd3, 8'd4, 8'd2};
      3: cells = {8'd0, 8'd3, 8'd2, 8'd3};
      4: cells = {8'd1, 8'd1, 8'd0, 8'd5};
      5: cells = {8'd4, 8'd0, 8'd2, 8'd3};
      6: cells = {8'd5, 8'd0, 8'd4, 8'd3};
      7: cells = {8'd0, 8'd3, 8'd32, 8'd1};
      8: cells = {8'd4, 8'd3, 8'd4, 8'd3};
      default: cells = {8'd4, 8'd3, 8'd2, 8'd6};
    endcase
    return cells[31 - 8 * pos -: 8];
  endfunction

  // Pixel rows of one custom glyph, top row in the upper bits.
  function automatic logic [39:0] glyph_pixels(int unsigned s);
    case (s)
      0: return {5'h1F, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      1: return {5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18};
      2: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h1F};
      3: return {5'h1F, 5'h1F, 5'h03, 5'h03, 5'h03, 5'h03, 5'h1F, 5'h1F};
      4: return {5'h1F, 5'h1F, 5'h18, 5'h18, 5'h18, 5'h18, 5'h1F, 5'h1F};
      5: return {5'h1F, 5'h1F, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18};
      6: return {5'h03, 5'h03, 5'h03, 5'h03, 5'h03, 5'h03, 5'h1F, 5'h1F};
      default: return {5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h18, 5'h1F, 5'h1F};
    endcase
  endfunction

  task automatic queue_op(input logic [1:0] kind, input int unsigned col,
                          input int unsigned row, input logic [7:0] code,
                          input int unsigned slot, input logic [39:0] glyph);
    bdc_pkg::out_item_t op;
    op       = '0;
    op.kind  = kind;
    op.col   = col[3:0];
    op.row   = row[0];
    op.code  = code;
    op.slot  = slot[2:0];
    op.glyph = glyph;
    pending_ops.push_back(op);
  endtask

  task automatic queue_pair(input int unsigned col, input logic [7:0] code);
    queue_op(bdc_pkg::KIND_CELL, col, 0, code, 0, '0);
    queue_op(bdc_pkg::KIND_CELL, col, 1, code, 0, '0);
  endtask

  task automatic queue_digit(input int unsigned d, input int unsigned col);
    queue_op(bdc_pkg::KIND_CELL, col, 0, digit_code(d, 0), 0, '0);
    queue_op(bdc_pkg::KIND_CELL, col + 1, 0, digit_code(d, 1), 0, '0);
    queue_op(bdc_pkg::KIND_CELL, col, 1, digit_code(d, 2), 0, '0);
    queue_op(bdc_pkg::KIND_CELL, col + 1, 1, digit_code(d, 3), 0, '0);
  endtask

  // Predicts the display operations caused by one accepted item.
  task automatic render_time(input bdc_pkg::in_item_t it);
    int unsigned        h12;
    int unsigned        tens;
    int unsigned        ones;
    logic               pm;
    bdc_pkg::out_item_t tail;
    if (!present_q) return;
    if (it.cmd == bdc_pkg::CMD_RELOAD) begin
      glyphs_loaded_q = 1'b1;
      n_reloads++;
      return;
    end
    h12 = it.hour % 12;
    if (h12 == 0) h12 = 12;
    pm = (it.hour >= 12);
    // A repeated time is not redrawn while the big glyphs are still in place.
    if (drawn_q && last_h12_q == h12[3:0] && last_min_q == it.minute &&
        !glyphs_loaded_q) begin
      n_skipped++;
      return;
    end
    last_h12_q = h12[3:0];
    last_min_q = it.minute;
    drawn_q    = 1'b1;
    // Loading the big glyphs takes two row blanks and eight definitions.
    if (glyphs_loaded_q) begin
      queue_op(bdc_pkg::KIND_BLANK, 0, 0, bdc_pkg::CH_SPACE, 0, '0);
      queue_op(bdc_pkg::KIND_BLANK, 0, 1, bdc_pkg::CH_SPACE, 0, '0);
      for (int unsigned s = 0; s < 8; s++) begin
        queue_op(bdc_pkg::KIND_GLYPH, 0, 0, 8'd0, s, glyph_pixels(s));
      end
      glyphs_loaded_q = 1'b0;
      n_full_draws++;
    end else begin
      n_redraws++;
    end
    tens = it.minute / 10;
    ones = it.minute % 10;
    // Two-digit hours start at column 0; single-digit hours are padded.
    if (h12 >= 10) begin
      queue_digit(h12 / 10, 0);
      queue_pair(2, bdc_pkg::CH_SPACE);
      queue_digit(h12 % 10, 3);
      queue_pair(5, bdc_pkg::CH_SPACE);
      queue_pair(6, bdc_pkg::CH_COLON);
      queue_pair(7, bdc_pkg::CH_SPACE);
      queue_digit(tens, 8);
      queue_pair(10, bdc_pkg::CH_SPACE);
      queue_digit(ones, 11);
      queue_pair(13, bdc_pkg::CH_SPACE);
    end else begin
      queue_pair(0, bdc_pkg::CH_SPACE);
      queue_pair(1, bdc_pkg::CH_SPACE);
      queue_digit(h12, 2);
      queue_pair(4, bdc_pkg::CH_SPACE);
      queue_pair(5, bdc_pkg::CH_COLON);
      queue_pair(6, bdc_pkg::CH_SPACE);
      queue_digit(tens, 7);
      queue_pair(9, bdc_pkg::CH_SPACE);
      queue_digit(ones, 10);
      queue_pair(12, bdc_pkg::CH_SPACE);
      queue_pair(13, bdc_pkg::CH_SPACE);
    end
    // The AM or PM marker sits in the last two columns.
    queue_op(bdc_pkg::KIND_CELL, 14, 0, pm ? bdc_pkg::CH_SPACE : bdc_pkg::CH_A, 0, '0);
    queue_op(bdc_pkg::KIND_CELL, 15, 0, pm ? bdc_pkg::CH_SPACE : bdc_pkg::CH_M, 0, '0);
    queue_op(bdc_pkg::KIND_CELL, 14, 1, pm ? bdc_pkg::CH_P : bdc_pkg::CH_SPACE, 0, '0);
    queue_op(bdc_pkg::KIND_CELL, 15, 1, pm ? bdc_pkg::CH_M : bdc_pkg::CH_SPACE, 0, '0);
    tail      = pending_ops.pop_back();
    tail.last = 1'b1;
    pending_ops.push_back(tail);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: operation %0d: %s", n_ops_checked, msg);
    n_errors++;
  endtask

  // Result side: random pops, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each popped operation is compared with the oldest pending one.
  always @(posedge clk_i) begin
    bdc_pkg::out_item_t want;
    if (rst_ni && pop_i && !empty_o) begin
      n_ops_checked++;
      if (pending_ops.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer kind %0d col %0d row %0d code %0d",
                                  out_item_o.kind, out_item_o.col, out_item_o.row,
                                  out_item_o.code));
      end else begin
        want = pending_ops.pop_front();
        if (out_item_o.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", out_item_o.kind, want.kind));
        if (out_item_o.col !== want.col)
          report_mismatch($sformatf("col got %0d want %0d", out_item_o.col, want.col));
        if (out_item_o.row !== want.row)
          report_mismatch($sformatf("row got %0d want %0d", out_item_o.row, want.row));
        if (out_item_o.code !== want.code)
          report_mismatch($sformatf("code got %0d want %0d", out_item_o.code, want.code));
        if (out_item_o.slot !== want.slot)
          report_mismatch($sformatf("slot got %0d want %0d", out_item_o.slot, want.slot));
        if (out_item_o.glyph !== want.glyph)
          report_mismatch($sformatf("glyph got %h want %h", out_item_o.glyph, want.glyph));
        if (out_item_o.last !== want.last)
          report_mismatch($sformatf("last got %0d want %0d", out_item_o.last, want.last));
      end
    end
  end

  // Offers one item, with random gaps, until the block takes it.
  task automatic send_item(input bdc_pkg::in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full_o);
    render_time(it);
    n_items++;
    if (it.cmd == bdc_pkg::CMD_DRAW) last_sent_q = it;
  endtask

  task automatic send_draw(input int unsigned hour, input int unsigned minute);
    bdc_pkg::in_item_t it;
    it.cmd    = bdc_pkg::CMD_DRAW;
    it.hour   = hour[4:0];
    it.minute = minute[5:0];
    send_item(it);
  endtask

  task automatic send_reload();
    bdc_pkg::in_item_t it;
    it.cmd    = bdc_pkg::CMD_RELOAD;
    it.hour   = 5'($urandom);
    it.minute = 6'($urandom);
    send_item(it);
  endtask

  // Lowers push, then waits until every operation has come and the block
  // has had time to finish items that cause none.
  task automatic wait_drained();
    @(negedge clk_i);
    push_i <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_display_present(input logic value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    present_q = value;
  endtask

  // Mostly legal times, some repeats that should be skipped, some repeats
  // with the other half of the day, reload notices and out-of-range values.
  function automatic bdc_pkg::in_item_t random_item();
    bdc_pkg::in_item_t it;
    int unsigned       roll;
    roll      = $urandom_range(99);
    it.cmd    = bdc_pkg::CMD_DRAW;
    it.hour   = ($urandom_range(99) < 85) ? 5'($urandom_range(23))
                                          : 5'($urandom_range(31, 24));
    it.minute = ($urandom_range(99) < 90) ? 6'($urandom_range(59))
                                          : 6'($urandom_range(63, 60));
    if (roll < 8) begin
      it.cmd = bdc_pkg::CMD_RELOAD;
    end else if (roll < 18) begin
      it = last_sent_q;
    end else if (roll < 24) begin
      it      = last_sent_q;
      it.hour = (it.hour < 12) ? it.hour + 5'd12 : ((it.hour < 24) ? it.hour - 5'd12 : it.hour);
    end
    return it;
  endfunction

  // Extremes, every digit, both halves of the day and each special case.
  task automatic test_directed();
    send_draw(0, 0);
    send_draw(0, 0);
    send_draw(12, 0);
    send_draw(23, 59);
    send_draw(9, 5);
    send_draw(10, 10);
    send_draw(1, 11);
    send_reload();
    send_draw(1, 11);
    send_draw(24, 0);
    send_draw(31, 63);
    send_draw(7, 60);
    send_draw(11, 62);
    send_draw(2, 34);
    send_draw(3, 47);
    send_draw(4, 58);
    send_draw(5, 6);
    send_draw(6, 17);
    send_draw(8, 28);
    send_draw(13, 39);
    send_draw(15, 41);
    send_draw(18, 52);
    wait_drained();
  endtask

  // Without a display nothing comes out and no state changes.
  task automatic test_no_display();
    set_display_present(1'b0);
    send_reload();
    for (int i = 0; i < 16; i++) send_item(random_item());
    send_reload();
    wait_drained();
    set_display_present(1'b1);
    // The last time drawn before must still be skipped.
    send_draw(last_h12_q, last_min_q);
    send_draw(last_h12_q, (last_min_q + 1) % 60);
    wait_drained();
  endtask

  // The result side holds off while full draws keep arriving.
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) begin
      send_reload();
      send_draw($urandom_range(23), $urandom_range(59));
    end
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) send_item(random_item());
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 16;
    recv_idle_pct = 74;
    set_display_present(1'b1);
    test_directed();
    test_no_display();
    test_backpressure();
    test_random(85, 16, 74);
    test_random(85, 74, 16);
    test_random(86, 0, 0);
    $display("Run covered %0d items: %0d full draws, %0d redraws, %0d skipped, %0d reloads",
             n_items, n_full_draws, n_redraws, n_skipped, n_reloads);
    $display("%0d display operations checked, %0d errors, %0d cycles",
             n_ops_checked, n_errors, cycle_count);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
